@@ rtl/core/epi_pkg.sv @@
// Shared types and constants for the particle Euler integrator.
// Holds request structs, controller/datapath command and status structs.
// No dependencies.
package epi_pkg;

    // Number of carried vector components and the number actually processed
    localparam int LANES        = 2;
    localparam int DIMENSIONS   = 2;
    localparam int ACTIVE_LANES = (DIMENSIONS < LANES) ? DIMENSIONS : LANES;

    // Restoring divider: one quotient bit per step
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int MASS_W   = 31;
    localparam logic [MASS_W-1:0] MASS_RESET = 31'd65536;
    localparam logic REG_MASS = 1'b0;

    // Operation codes
    localparam logic [1:0] OP_FORCE   = 2'd0;
    localparam logic [1:0] OP_SET_POS = 2'd1;
    localparam logic [1:0] OP_SET_VEL = 2'd2;
    localparam logic [1:0] OP_UPDATE  = 2'd3;

    // Q16.16 saturation limits
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic [30:0]        time_step;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic               zero_mass_error;
        logic               saturated;
    } out_req_t;

    typedef struct packed {
        logic start;
        logic force_add;
        logic set_pos;
        logic set_vel;
        logic set_err;
        logic div_load;
        logic div_step;
        logic acc_fix;
        logic mul_acc;
        logic mul_vel;
        logic vel_add;
        logic pos_add;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       mass_zero;
    } ctrl_sts_t;

endpackage

@@ rtl/core/epi_datapath.sv @@
// Datapath of the particle Euler integrator: state vectors, per-lane
// restoring divider, multiplier and saturating adders, result register.
// Depends on epi_pkg.
module epi_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  epi_pkg::ctrl_cmd_t        cmd,
    input  epi_pkg::in_req_t          in_data,
    input  logic [epi_pkg::MASS_W-1:0] mass,
    output epi_pkg::ctrl_sts_t        sts,
    output epi_pkg::out_req_t         out_data
);

    // Item registers
    logic [1:0]         op_reg, op_next;
    logic [30:0]        dt_reg, dt_next;
    logic signed [31:0] val_reg [epi_pkg::LANES];
    logic signed [31:0] val_next[epi_pkg::LANES];
    logic               sat_reg, sat_next;
    logic               err_reg, err_next;

    // Particle state
    logic signed [31:0] pos_reg [epi_pkg::LANES];
    logic signed [31:0] pos_next[epi_pkg::LANES];
    logic signed [31:0] vel_reg [epi_pkg::LANES];
    logic signed [31:0] vel_next[epi_pkg::LANES];
    logic signed [31:0] frc_reg [epi_pkg::LANES];
    logic signed [31:0] frc_next[epi_pkg::LANES];

    // Divider and multiplier working registers
    logic [30:0]        rem_reg [epi_pkg::LANES];
    logic [30:0]        rem_next[epi_pkg::LANES];
    logic [31:0]        dvd_reg [epi_pkg::LANES];
    logic [31:0]        dvd_next[epi_pkg::LANES];
    logic [31:0]        quo_reg [epi_pkg::LANES];
    logic [31:0]        quo_next[epi_pkg::LANES];
    logic               neg_reg [epi_pkg::LANES];
    logic               neg_next[epi_pkg::LANES];
    logic               ovf_reg [epi_pkg::LANES];
    logic               ovf_next[epi_pkg::LANES];
    logic signed [31:0] acc_reg [epi_pkg::LANES];
    logic signed [31:0] acc_next[epi_pkg::LANES];
    logic [46:0]        prod_reg [epi_pkg::LANES];
    logic [46:0]        prod_next[epi_pkg::LANES];
    logic               pneg_reg [epi_pkg::LANES];
    logic               pneg_next[epi_pkg::LANES];

    epi_pkg::out_req_t  out_reg, out_next;

    // Per-lane combinational helpers
    logic [31:0]        frc_mag [epi_pkg::LANES];
    logic [31:0]        shifted [epi_pkg::LANES];
    logic signed [31:0] mul_src [epi_pkg::LANES];
    logic [31:0]        mul_mag [epi_pkg::LANES];
    logic [62:0]        mul_full[epi_pkg::LANES];
    logic signed [48:0] term    [epi_pkg::LANES];
    logic signed [48:0] sum     [epi_pkg::LANES];

    function automatic logic signed [31:0] clamp_word(input logic signed [48:0] s);
        logic signed [31:0] r;
        if (s > 49'sd2147483647)
            r = epi_pkg::WORD_MAX;
        else if (s < -49'sd2147483648)
            r = epi_pkg::WORD_MIN;
        else
            r = s[31:0];
        return r;
    endfunction

    function automatic logic over_word(input logic signed [48:0] s);
        return (s > 49'sd2147483647) || (s < -49'sd2147483648);
    endfunction

    assign sts.op        = op_reg;
    assign sts.mass_zero = (mass == '0);
    assign out_data      = out_reg;

    // Next-state logic for every register
    always_comb
    begin
        op_next  = op_reg;
        dt_next  = dt_reg;
        sat_next = sat_reg;
        err_next = err_reg;
        out_next = out_reg;
        for (int i = 0; i < epi_pkg::LANES; i++)
        begin
            val_next[i]  = val_reg[i];
            pos_next[i]  = pos_reg[i];
            vel_next[i]  = vel_reg[i];
            frc_next[i]  = frc_reg[i];
            rem_next[i]  = rem_reg[i];
            dvd_next[i]  = dvd_reg[i];
            quo_next[i]  = quo_reg[i];
            neg_next[i]  = neg_reg[i];
            ovf_next[i]  = ovf_reg[i];
            acc_next[i]  = acc_reg[i];
            prod_next[i] = prod_reg[i];
            pneg_next[i] = pneg_reg[i];

            frc_mag[i]  = frc_reg[i][31] ? 32'(-frc_reg[i]) : 32'(frc_reg[i]);
            shifted[i]  = {rem_reg[i], dvd_reg[i][31]};
            mul_src[i]  = cmd.mul_acc ? acc_reg[i] : vel_reg[i];
            mul_mag[i]  = mul_src[i][31] ? 32'(-mul_src[i]) : 32'(mul_src[i]);
            mul_full[i] = 63'(mul_mag[i]) * 63'(dt_reg);
            term[i]     = pneg_reg[i] ? -signed'({2'b00, prod_reg[i]})
                                      : signed'({2'b00, prod_reg[i]});
            sum[i]      = '0;
        end

        // Capture the request and clear the per-item flags
        if (cmd.start)
        begin
            op_next     = in_data.operation;
            dt_next     = in_data.time_step;
            val_next[0] = in_data.value_x;
            val_next[1] = in_data.value_y;
            sat_next    = 1'b0;
            err_next    = 1'b0;
        end

        if (cmd.set_err)
            err_next = 1'b1;

        for (int i = 0; i < epi_pkg::LANES; i++)
        begin
            if (i < epi_pkg::ACTIVE_LANES)
            begin
                // Accumulate force with saturation
                if (cmd.force_add)
                begin
                    sum[i]      = 49'(frc_reg[i]) + 49'(val_reg[i]);
                    frc_next[i] = clamp_word(sum[i]);
                    if (over_word(sum[i]))
                        sat_next = 1'b1;
                end
                if (cmd.set_pos)
                    pos_next[i] = val_reg[i];
                if (cmd.set_vel)
                    vel_next[i] = val_reg[i];

                // Seed the divider; a quotient of 2^32 or more clamps anyway
                if (cmd.div_load)
                begin
                    neg_next[i] = frc_reg[i][31];
                    ovf_next[i] = {15'd0, frc_mag[i][31:16]} >= mass;
                    rem_next[i] = 31'(frc_mag[i][31:16]);
                    dvd_next[i] = {frc_mag[i][15:0], 16'h0000};
                    quo_next[i] = '0;
                end

                // One restoring step per cycle
                if (cmd.div_step)
                begin
                    dvd_next[i] = {dvd_reg[i][30:0], 1'b0};
                    if (shifted[i] >= {1'b0, mass})
                    begin
                        rem_next[i] = 31'(shifted[i] - {1'b0, mass});
                        quo_next[i] = {quo_reg[i][30:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = shifted[i][30:0];
                        quo_next[i] = {quo_reg[i][30:0], 1'b0};
                    end
                end

                // Apply sign and clamp the acceleration
                if (cmd.acc_fix)
                begin
                    if (ovf_reg[i])
                    begin
                        acc_next[i] = neg_reg[i] ? epi_pkg::WORD_MIN : epi_pkg::WORD_MAX;
                        sat_next    = 1'b1;
                    end
                    else if (!neg_reg[i])
                    begin
                        if (quo_reg[i][31])
                        begin
                            acc_next[i] = epi_pkg::WORD_MAX;
                            sat_next    = 1'b1;
                        end
                        else
                            acc_next[i] = signed'(quo_reg[i]);
                    end
                    else
                    begin
                        if (quo_reg[i] > 32'h8000_0000)
                        begin
                            acc_next[i] = epi_pkg::WORD_MIN;
                            sat_next    = 1'b1;
                        end
                        else
                            acc_next[i] = signed'(-quo_reg[i]);
                    end
                end

                // Register the scaled magnitude product
                if (cmd.mul_acc || cmd.mul_vel)
                begin
                    prod_next[i] = mul_full[i][62:16];
                    pneg_next[i] = mul_src[i][31];
                end

                if (cmd.vel_add)
                begin
                    sum[i]      = 49'(vel_reg[i]) + term[i];
                    vel_next[i] = clamp_word(sum[i]);
                    if (over_word(sum[i]))
                        sat_next = 1'b1;
                end

                // Advance position and drop the force accumulator
                if (cmd.pos_add)
                begin
                    sum[i]      = 49'(pos_reg[i]) + term[i];
                    pos_next[i] = clamp_word(sum[i]);
                    frc_next[i] = '0;
                    if (over_word(sum[i]))
                        sat_next = 1'b1;
                end
            end
        end

        if (cmd.out_load)
        begin
            out_next.position_x      = pos_reg[0];
            out_next.position_y      = pos_reg[1];
            out_next.velocity_x      = vel_reg[0];
            out_next.velocity_y      = vel_reg[1];
            out_next.zero_mass_error = err_reg;
            out_next.saturated       = sat_reg;
        end
    end

    // Particle state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < epi_pkg::LANES; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                frc_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < epi_pkg::LANES; i++)
            begin
                pos_reg[i] <= pos_next[i];
                vel_reg[i] <= vel_next[i];
                frc_reg[i] <= frc_next[i];
            end
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        dt_reg  <= dt_next;
        sat_reg <= sat_next;
        err_reg <= err_next;
        out_reg <= out_next;
        for (int i = 0; i < epi_pkg::LANES; i++)
        begin
            val_reg[i]  <= val_next[i];
            rem_reg[i]  <= rem_next[i];
            dvd_reg[i]  <= dvd_next[i];
            quo_reg[i]  <= quo_next[i];
            neg_reg[i]  <= neg_next[i];
            ovf_reg[i]  <= ovf_next[i];
            acc_reg[i]  <= acc_next[i];
            prod_reg[i] <= prod_next[i];
            pneg_reg[i] <= pneg_next[i];
        end
    end

endmodule

@@ rtl/core/epi_controller.sv @@
// Sequencer of the particle Euler integrator: request handshake, operation
// steps, divider step count and result valid. Depends on epi_pkg.
module epi_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  epi_pkg::ctrl_sts_t sts,
    output epi_pkg::ctrl_cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_MULA = 4'd4;
    localparam logic [3:0] S_VADD = 4'd5;
    localparam logic [3:0] S_MULV = 4'd6;
    localparam logic [3:0] S_PADD = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]                  state_reg, state_next;
    logic [epi_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Step through the operation
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.op)
                    epi_pkg::OP_FORCE:
                    begin
                        cmd.force_add = 1'b1;
                        state_next    = S_DONE;
                    end
                    epi_pkg::OP_SET_POS:
                    begin
                        cmd.set_pos = 1'b1;
                        state_next  = S_DONE;
                    end
                    epi_pkg::OP_SET_VEL:
                    begin
                        cmd.set_vel = 1'b1;
                        state_next  = S_DONE;
                    end
                    default:
                    begin
                        if (sts.mass_zero)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = S_MULV;
                        end
                        else
                        begin
                            cmd.div_load = 1'b1;
                            cnt_next     = '0;
                            state_next   = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == epi_pkg::DIV_CNT_W'(epi_pkg::DIV_STEPS - 1))
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_fix = 1'b1;
                state_next  = S_MULA;
            end
            S_MULA:
            begin
                cmd.mul_acc = 1'b1;
                state_next  = S_VADD;
            end
            S_VADD:
            begin
                cmd.vel_add = 1'b1;
                state_next  = S_MULV;
            end
            S_MULV:
            begin
                cmd.mul_vel = 1'b1;
                state_next  = S_PADD;
            end
            S_PADD:
            begin
                cmd.pos_add = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, drop when taken
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/particle_euler_integrator_top.sv @@
// Top level of the 2-D semi-implicit Euler integrator for one point mass.
// Holds the mass register and configuration port; instantiates the
// controller and datapath. Depends on epi_pkg, epi_controller, epi_datapath.
//
// Usage:
//   Requests enter on in_valid/in_ready/in_data, one at a time; each gives
//   one result on out_valid/out_ready/out_data with position, velocity and
//   the zero-mass and saturation flags. Mass is written over the APB port
//   (register 0 at address 0); the user must write it only while the block
//   is idle, as the block itself does not enforce this. pready is tied high.
//   Apply force, set position and set velocity go from the execute state
//   straight to the done state; an update with zero mass skips the divider
//   and only advances position by the velocity; an update runs the 32-step
//   restoring divider (one quotient bit per cycle, both lanes in parallel)
//   followed by the multiply/add steps for velocity and position. in_ready
//   rises together with out_valid; no new request is taken before then.
//   A finished result waits in an output register; while it waits the
//   block takes and works on the next request, and only stalls that one
//   before loading its result. Reset clears position, velocity and force
//   to zero, sets mass to 1.0 and drops out_valid.
module particle_euler_integrator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [epi_pkg::PADDR_W-1:0] paddr,
    input  logic [epi_pkg::PDATA_W-1:0] pwdata,
    output logic [epi_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  epi_pkg::in_req_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output epi_pkg::out_req_t           out_data
);

    logic [epi_pkg::MASS_W-1:0] mass_reg, mass_next;
    logic                       reg_sel;
    epi_pkg::ctrl_cmd_t         cmd;
    epi_pkg::ctrl_sts_t         sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == epi_pkg::REG_MASS);
    assign prdata  = reg_sel ? {1'b0, mass_reg} : '0;

    // Write the mass register on the access cycle
    always_comb
    begin
        mass_next = mass_reg;
        if (psel && penable && pwrite && pready && reg_sel)
            mass_next = pwdata[epi_pkg::MASS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mass_reg <= epi_pkg::MASS_RESET;
        else
            mass_reg <= mass_next;
    end

    epi_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    epi_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .mass     (mass_reg),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

@@ rtl/core/epi_checker.sv @@
// Port-level checks for the particle Euler integrator, bound to the top.
// Depends on epi_pkg and particle_euler_integrator_top.
module epi_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input epi_pkg::out_req_t out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One request at a time: ready drops after acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // No result appears in the cycle right after a request is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

    // A new result comes with the block idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result loaded while still busy");

endmodule

bind particle_euler_integrator_top epi_checker u_epi_checker (.*);
